@@ rtl/core/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int OFS_W  = 16;
  localparam int SIZE_W = 17;
  localparam int ADDR_W = 32;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] POOL_LIMIT = 17'h10000;
  localparam logic [SIZE_W-1:0] ALIGN_MASK = 17'd3;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD      = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [OFS_W-1:0]  start;
    logic [SIZE_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic              ready;
    logic [SIZE_W-1:0] pool_end;
    logic [ADDR_W-1:0] base_hdr;
  } cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] peak;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/ffba_walker.sv @@
// ----------------------------------------------------------------------------
// ffba_walker
// Block table memory and the sequencer that walks, inserts and removes entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_walker #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          init,
  input  wire ffba_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               busy,
  input  wire logic                          action,
  input  wire logic [15:0]                   request_bytes,
  input  wire logic [ffba_pkg::ADDR_W-1:0]   block_address,
  output logic                               res_valid,
  output ffba_pkg::result_t                  res,
  input  wire logic                          res_take
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SW    = ffba_pkg::SIZE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_SHUP = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_SHDN = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  ffba_pkg::entry_t mem [MAX_BLOCKS];
  ffba_pkg::entry_t rd_q;
  ffba_pkg::entry_t e;
  ffba_pkg::entry_t wr_data;
  logic             rd_head;
  logic             head_valid;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  logic [2:0]                  state;
  logic [CNT_W-1:0]            cnt;
  logic [SW-1:0]               used;
  logic [SW-1:0]               peak;
  logic                        is_free;
  logic [SW-1:0]               need;
  logic [ffba_pkg::ADDR_W-1:0] target_ofs;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            ins;
  logic [ffba_pkg::OFS_W-1:0]  prev_start;
  logic [SW:0]                 prev_end;
  logic [SW+1:0]               prev_need_end;
  logic [SW-1:0]               prev_len;
  logic [IDX_W-1:0]            prev_idx;
  logic [ffba_pkg::STAT_W-1:0] res_status;
  logic [ffba_pkg::ADDR_W-1:0] res_granted;

  logic                        in_accept;
  logic                        bad_in;
  logic [SW-1:0]               need_in;
  logic [SW:0]                 e_end;
  logic [SW+1:0]               e_need_end;
  logic                        last;
  logic                        gap_ok;
  logic                        tail_ok;
  logic                        match;
  logic                        place_go;
  logic                        table_full;
  logic                        no_shift;
  logic [SW-1:0]               used_add;
  logic [SW-1:0]               used_sub;
  logic [SW-1:0]               peak_add;
  logic [CNT_W-1:0]            cnt_m1;

  assign busy      = (state != S_IDLE);
  assign in_accept = in_valid && (state == S_IDLE);
  assign need_in   = (SW'(request_bytes) + SW'(HEADER_BYTES) + ffba_pkg::ALIGN_MASK)
                     & ~ffba_pkg::ALIGN_MASK;
  assign bad_in    = !cfg.ready
                     || ((action == ffba_pkg::ACT_ALLOC) && (request_bytes == '0))
                     || ((action == ffba_pkg::ACT_FREE) && (block_address == '0));

  assign e          = rd_head ? '0 : rd_q;
  assign e_end      = (SW+1)'(e.start) + (SW+1)'(e.length);
  assign e_need_end = (SW+2)'(e_end) + (SW+2)'(need);
  assign last       = ((CNT_W'(idx) + CNT_W'(1)) == cnt);
  assign gap_ok     = (idx != '0) && ((SW+2)'(e.start) >= prev_need_end);
  assign tail_ok    = ((SW+2)'(cfg.pool_end) >= prev_need_end);
  assign match      = (ffba_pkg::ADDR_W'(e.start) == target_ofs);
  assign place_go   = ((state == S_WALK) && !is_free && gap_ok)
                      || ((state == S_TAIL) && tail_ok);
  assign table_full = (cnt == CNT_W'(MAX_BLOCKS));
  assign no_shift   = ((CNT_W'(prev_idx) + CNT_W'(1)) == cnt);
  assign used_add   = used + need;
  assign used_sub   = (used >= e.length) ? (used - e.length) : '0;
  assign peak_add   = (used_add > peak) ? used_add : peak;
  assign cnt_m1     = cnt - CNT_W'(1);

  assign res_valid   = (state == S_RESP);
  assign res.status  = res_status;
  assign res.granted = res_granted;
  assign res.used    = used;
  assign res.peak    = peak;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state) inside
      S_IDLE: begin
        if (in_accept && !bad_in) begin
          rd_en = 1'b1;
        end
      end
      S_WALK, S_TAIL: begin
        if (place_go) begin
          if (prev_len == '0) begin
            wr_en         = 1'b1;
            wr_addr       = prev_idx;
            wr_data.start = prev_start;
            wr_data.length = need;
          end else if (!table_full && !no_shift) begin
            rd_en   = 1'b1;
            rd_addr = cnt_m1[IDX_W-1:0];
          end
        end else if (state == S_WALK) begin
          if (is_free && match && (idx == '0)) begin
            wr_en = 1'b1;
          end else if (!last) begin
            rd_en   = 1'b1;
            rd_addr = idx + IDX_W'(1);
          end
        end
      end
      S_SHUP: begin
        wr_en   = 1'b1;
        wr_addr = idx + IDX_W'(1);
        wr_data = e;
        if (idx != ins) begin
          rd_en   = 1'b1;
          rd_addr = idx - IDX_W'(1);
        end
      end
      S_INS: begin
        wr_en          = 1'b1;
        wr_addr        = ins;
        wr_data.start  = prev_end[ffba_pkg::OFS_W-1:0];
        wr_data.length = need;
      end
      S_SHDN: begin
        wr_en   = 1'b1;
        wr_addr = idx - IDX_W'(1);
        wr_data = e;
        if (!last) begin
          rd_en   = 1'b1;
          rd_addr = idx + IDX_W'(1);
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_head <= (rd_addr == '0) && !head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || init) begin
      head_valid <= 1'b0;
    end else if (wr_en && (wr_addr == '0)) begin
      head_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= CNT_W'(1);
      used  <= '0;
      peak  <= '0;
    end else if (init) begin
      cnt  <= CNT_W'(1);
      used <= '0;
      peak <= '0;
    end else begin
      unique case (state) inside
        S_IDLE: begin
          if (in_accept) begin
            is_free     <= (action == ffba_pkg::ACT_FREE);
            need        <= need_in;
            target_ofs  <= block_address - cfg.base_hdr;
            idx         <= '0;
            res_granted <= '0;
            if (bad_in) begin
              res_status <= ffba_pkg::ST_BAD;
              state      <= S_RESP;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK, S_TAIL: begin
          if (place_go) begin
            if (prev_len == '0) begin
              used        <= used_add;
              peak        <= peak_add;
              res_status  <= ffba_pkg::ST_DONE;
              res_granted <= cfg.base_hdr + ffba_pkg::ADDR_W'(prev_start);
              state       <= S_RESP;
            end else if (table_full) begin
              res_status <= ffba_pkg::ST_NO_SPACE;
              state      <= S_RESP;
            end else begin
              used        <= used_add;
              peak        <= peak_add;
              res_status  <= ffba_pkg::ST_DONE;
              res_granted <= cfg.base_hdr + ffba_pkg::ADDR_W'(prev_end);
              ins         <= prev_idx + IDX_W'(1);
              if (no_shift) begin
                state <= S_INS;
              end else begin
                idx   <= cnt_m1[IDX_W-1:0];
                state <= S_SHUP;
              end
            end
          end else if (state == S_TAIL) begin
            res_status <= ffba_pkg::ST_NO_SPACE;
            state      <= S_RESP;
          end else if (!is_free) begin
            prev_start    <= e.start;
            prev_end      <= e_end;
            prev_need_end <= e_need_end;
            prev_len      <= e.length;
            prev_idx      <= idx;
            if (last) begin
              state <= S_TAIL;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end else if (match) begin
            used       <= used_sub;
            res_status <= ffba_pkg::ST_DONE;
            if (idx == '0) begin
              state <= S_RESP;
            end else if (last) begin
              cnt   <= cnt_m1;
              state <= S_RESP;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_SHDN;
            end
          end else if (last) begin
            res_status <= ffba_pkg::ST_BAD;
            state      <= S_RESP;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_SHUP: begin
          if (idx == ins) begin
            state <= S_INS;
          end else begin
            idx <= idx - IDX_W'(1);
          end
        end
        S_INS: begin
          cnt   <= cnt + CNT_W'(1);
          state <= S_RESP;
        end
        S_SHDN: begin
          if (last) begin
            cnt   <= cnt_m1;
            state <= S_RESP;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_RESP: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && (cnt <= CNT_W'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_peak_ge_used: assert property (@(posedge clk) disable iff (rst)
    peak >= used)
    else $error("peak below used bytes");

  a_take_to_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_take && !init) |=> (state == S_IDLE))
    else $error("result transfer did not release the sequencer");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_IDLE) && (state != S_RESP))
    else $error("table write outside an operation");

  a_shift_no_head: assert property (@(posedge clk) disable iff (rst)
    (wr_en && ((state == S_SHUP) || (state == S_SHDN) || (state == S_INS)))
      |-> (wr_addr != '0))
    else $error("shift or insert wrote the head entry");
`endif

endmodule

`default_nettype wire

@@ rtl/core/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a byte pool with an address-ordered block table.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid / in_stall     action, request_bytes, block_address
//  out       out_valid / out_stall   status, granted_address, used_bytes, peak_bytes
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One table read per cycle walks the list; the shift on remove continues
//  from where the walk stopped, and the shift on insert runs down from the
//  table end to the new slot, one read/write per cycle. One item is in
//  work at a time; the output register lets the next item enter while a
//  result waits on out_stall. Reset and every cfg transfer empty the table
//  (head entry only, no clearing pass); input stalls in a cfg transfer cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS       = 64,
  parameter int HEADER_BYTES     = 8,
  parameter int END_MARKER_BYTES = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             action,
  input  wire logic [15:0]                      request_bytes,
  input  wire logic [ffba_pkg::ADDR_W-1:0]      block_address,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ffba_pkg::STAT_W-1:0]           status,
  output logic [ffba_pkg::ADDR_W-1:0]           granted_address,
  output logic [ffba_pkg::SIZE_W-1:0]           used_bytes,
  output logic [ffba_pkg::SIZE_W-1:0]           peak_bytes,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ffba_pkg::ADDR_W-1:0]      cfg_data
);

  localparam int SW = ffba_pkg::SIZE_W;

  logic [ffba_pkg::ADDR_W-1:0] pool_base;
  logic [ffba_pkg::ADDR_W-1:0] base_hdr;
  logic [SW-1:0]               pool_size;
  logic [SW-1:0]               eff_size;
  logic                        init;
  logic                        busy;
  logic                        res_valid;
  logic                        res_take;
  ffba_pkg::cfg_t              cfg;
  ffba_pkg::result_t           res;

  assign cfg_ready = 1'b1;
  assign init      = cfg_valid && cfg_ready;
  assign in_stall  = busy || init;

  assign eff_size     = (pool_size > ffba_pkg::POOL_LIMIT) ? ffba_pkg::POOL_LIMIT : pool_size;
  assign cfg.ready    = (pool_base != '0) && (eff_size >= SW'(HEADER_BYTES))
                        && (eff_size >= SW'(END_MARKER_BYTES));
  assign cfg.pool_end = eff_size - SW'(END_MARKER_BYTES);
  assign cfg.base_hdr = base_hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      base_hdr  <= ffba_pkg::ADDR_W'(HEADER_BYTES);
      pool_size <= '0;
    end else if (init) begin
      unique case (cfg_index)
        ffba_pkg::CFG_POOL_BASE: begin
          pool_base <= cfg_data;
          base_hdr  <= cfg_data + ffba_pkg::ADDR_W'(HEADER_BYTES);
        end
        ffba_pkg::CFG_POOL_SIZE: begin
          pool_size <= cfg_data[SW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ffba_walker #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .init          (init),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .busy          (busy),
    .action        (action),
    .request_bytes (request_bytes),
    .block_address (block_address),
    .res_valid     (res_valid),
    .res           (res),
    .res_take      (res_take)
  );

  // load the output register when empty or when its transfer completes
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status          <= res.status;
      granted_address <= res.granted;
      used_bytes      <= res.used;
      peak_bytes      <= res.peak;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking testbench of the first-fit block allocator. A shadow copy of
// the block table predicts status, granted address, used and peak bytes for
// every request accepted. Each response is compared with the oldest
// prediction. Named tests cover the uninitialized pool, edge cases, a full
// block table, random traffic over several pool settings, a stretch without
// idle cycles and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLK      = 64;
  localparam int HDR          = 8;
  localparam int END_MARK     = 4;
  localparam int DRAIN_CYCLES = 2 * MAX_BLK + 16;
  localparam int IDLE_PCT     = 31;
  localparam int AW           = ffba_pkg::ADDR_W;
  localparam int SW           = ffba_pkg::SIZE_W;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           action = ffba_pkg::ACT_ALLOC;
  logic [15:0]                    request_bytes = '0;
  logic [AW-1:0]                  block_address = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ffba_pkg::STAT_W-1:0]    status;
  logic [AW-1:0]                  granted_address;
  logic [SW-1:0]                  used_bytes;
  logic [SW-1:0]                  peak_bytes;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index = ffba_pkg::CFG_POOL_BASE;
  logic [AW-1:0]                  cfg_data = '0;

  logic [AW-1:0]               shadow_base;
  logic [SW-1:0]               shadow_size;
  logic [ffba_pkg::OFS_W-1:0]  table_start [MAX_BLK];
  logic [SW-1:0]               table_len [MAX_BLK];
  int unsigned                 table_entries;
  logic [SW-1:0]               shadow_used;
  logic [SW-1:0]               shadow_peak;

  ffba_pkg::result_t    answer_q[$];
  logic [AW-1:0]        live_addrs[$];
  int unsigned          phase_span = 0;
  bit                   in_gaps_on = 1'b1;
  bit                   out_gaps_on = 1'b1;
  int                   hold_req = 0;
  int                   errors = 0;

  first_fit_block_allocator #(
    .MAX_BLOCKS      (MAX_BLK),
    .HEADER_BYTES    (HDR),
    .END_MARKER_BYTES(END_MARK)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .request_bytes  (request_bytes),
    .block_address  (block_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .granted_address(granted_address),
    .used_bytes     (used_bytes),
    .peak_bytes     (peak_bytes),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned effective_span();
    return (shadow_size > ffba_pkg::POOL_LIMIT) ? 32'(ffba_pkg::POOL_LIMIT)
                                                : 32'(shadow_size);
  endfunction

  function automatic void clear_table();
    for (int j = 0; j < MAX_BLK; j++) begin
      table_start[j] = '0;
      table_len[j]   = '0;
    end
    table_entries = 1;
    shadow_used   = '0;
    shadow_peak   = '0;
    live_addrs.delete();
  endfunction

  function automatic ffba_pkg::result_t compute_answer(input logic act,
                                                       input logic [15:0] req,
                                                       input logic [AW-1:0] addr);
    ffba_pkg::result_t r;
    int unsigned       span, limit, need, nxt, tail, gap, i, k;
    logic [AW-1:0]     target;
    bit                found;
    r.status  = ffba_pkg::ST_BAD;
    r.granted = '0;
    span      = effective_span();
    found     = 1'b0;
    if (shadow_base != 0 && span >= HDR && span >= END_MARK) begin
      if (act == ffba_pkg::ACT_ALLOC) begin
        if (req != 0) begin
          r.status = ffba_pkg::ST_NO_SPACE;
          need  = req + HDR + ffba_pkg::ALIGN_MASK;
          need  = need - (need & ffba_pkg::ALIGN_MASK);
          limit = span - END_MARK;
          for (i = 0; i < table_entries && !found; i++) begin
            nxt  = (i + 1 < table_entries) ? table_start[i+1] : limit;
            tail = table_start[i] + table_len[i];
            gap  = (nxt < tail) ? 0 : nxt - tail;
            if (gap >= need) begin
              found = 1'b1;
              if (table_len[i] == 0) begin
                table_len[i] = SW'(need);
                r.status  = ffba_pkg::ST_DONE;
                r.granted = shadow_base + table_start[i] + HDR;
              end else if (table_entries < MAX_BLK) begin
                for (k = table_entries; k > i + 1; k--) begin
                  table_start[k] = table_start[k-1];
                  table_len[k]   = table_len[k-1];
                end
                table_start[i+1] = ffba_pkg::OFS_W'(tail);
                table_len[i+1]   = SW'(need);
                table_entries++;
                r.status  = ffba_pkg::ST_DONE;
                r.granted = shadow_base + tail + HDR;
              end
              if (r.status == ffba_pkg::ST_DONE) begin
                shadow_used = SW'(shadow_used + need);
                if (shadow_used > shadow_peak) shadow_peak = shadow_used;
              end
            end
          end
        end
      end else if (addr != 0) begin
        target = addr - HDR;
        for (i = 0; i < table_entries && !found; i++) begin
          if (shadow_base + table_start[i] == target) begin
            found = 1'b1;
            r.status = ffba_pkg::ST_DONE;
            shadow_used = (shadow_used >= table_len[i]) ? shadow_used - table_len[i] : '0;
            if (i == 0) begin
              table_len[0] = '0;
            end else begin
              for (k = i; k + 1 < table_entries; k++) begin
                table_start[k] = table_start[k+1];
                table_len[k]   = table_len[k+1];
              end
              table_entries--;
            end
          end
        end
      end
    end
    r.used = shadow_used;
    r.peak = shadow_peak;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_answer();
    ffba_pkg::result_t want;
    if (answer_q.size() == 0) begin
      $display("%0t: response with none pending, expected nothing, actual status %0d addr %h",
               $time, status, granted_address);
      errors++;
    end else begin
      want = answer_q.pop_front();
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("granted_address", want.granted, granted_address);
      compare_field("used_bytes", 32'(want.used), 32'(used_bytes));
      compare_field("peak_bytes", 32'(want.peak), 32'(peak_bytes));
    end
  endfunction

  initial begin : response_monitor
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_answer();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= out_gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_request(input logic act, input logic [15:0] req,
                              input logic [AW-1:0] addr);
    ffba_pkg::result_t ans;
    int                j;
    while (in_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    request_bytes <= req;
    block_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ans = compute_answer(act, req, addr);
    answer_q.push_back(ans);
    if (ans.status == ffba_pkg::ST_DONE) begin
      if (act == ffba_pkg::ACT_ALLOC) begin
        live_addrs.push_back(ans.granted);
      end else begin
        j = 0;
        while (j < live_addrs.size() && live_addrs[j] != addr) j++;
        if (j < live_addrs.size()) live_addrs.delete(j);
      end
    end
  endtask

  task automatic write_register(input logic [ffba_pkg::CFG_IDX_W-1:0] idx,
                                input logic [AW-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ffba_pkg::CFG_POOL_BASE) shadow_base = data;
    else shadow_size = data[SW-1:0];
    clear_table();
    phase_span = effective_span();
  endtask

  task automatic set_pool(input logic [AW-1:0] base, input logic [AW-1:0] size_word);
    write_register(ffba_pkg::CFG_POOL_BASE, base);
    write_register(ffba_pkg::CFG_POOL_SIZE, size_word);
  endtask

  function automatic logic [AW-1:0] nonzero_base();
    logic [AW-1:0] b;
    b = $urandom;
    return (b == 0) ? 32'h0000_0100 : b;
  endfunction

  task automatic send_random_op();
    int unsigned   pick, cap;
    logic [AW-1:0] near;
    pick = $urandom_range(99);
    cap  = (phase_span > 64) ? phase_span / 4 : 16;
    near = (live_addrs.size() != 0) ? live_addrs[0] + 4 : shadow_base + HDR + 4;
    if (pick < 35 && live_addrs.size() != 0) begin
      send_request(ffba_pkg::ACT_FREE, 16'($urandom),
                   live_addrs[$urandom_range(live_addrs.size() - 1)]);
    end else if (pick < 60) begin
      send_request(ffba_pkg::ACT_ALLOC, 16'($urandom_range(1, 64)), $urandom);
    end else if (pick < 78) begin
      send_request(ffba_pkg::ACT_ALLOC, 16'($urandom_range(1, cap)), $urandom);
    end else begin
      case (pick % 7)
        0: send_request(ffba_pkg::ACT_FREE, 16'($urandom), $urandom);
        1: send_request(ffba_pkg::ACT_FREE, 16'($urandom), '0);
        2: send_request(ffba_pkg::ACT_FREE, 16'($urandom), near);
        3: send_request(ffba_pkg::ACT_ALLOC, '0, $urandom);
        4: send_request(ffba_pkg::ACT_ALLOC, 16'($urandom), $urandom);
        5: send_request(ffba_pkg::ACT_FREE, 16'($urandom), shadow_base + HDR);
        default: send_request(ffba_pkg::ACT_FREE, 16'($urandom),
                              shadow_base + phase_span - END_MARK + HDR);
      endcase
    end
  endtask

  task automatic test_not_initialised();
    send_request(ffba_pkg::ACT_ALLOC, 16'd16, '0);
    send_request(ffba_pkg::ACT_FREE, '0, 32'd8);
    write_register(ffba_pkg::CFG_POOL_BASE, 32'h0000_1000);
    send_request(ffba_pkg::ACT_ALLOC, 16'd4, '0);
    write_register(ffba_pkg::CFG_POOL_SIZE, 32'd7);
    send_request(ffba_pkg::ACT_ALLOC, 16'd1, '0);
    set_pool('0, 32'd4096);
    repeat (10) send_random_op();
  endtask

  task automatic test_edge_cases();
    set_pool(32'h0000_1000, 32'd8);
    send_request(ffba_pkg::ACT_ALLOC, 16'd1, '0);
    write_register(ffba_pkg::CFG_POOL_SIZE, 32'd16);
    send_request(ffba_pkg::ACT_ALLOC, 16'd1, '0);
    send_request(ffba_pkg::ACT_ALLOC, 16'd1, '0);
    send_request(ffba_pkg::ACT_FREE, '0, 32'h0000_1008);
    send_request(ffba_pkg::ACT_FREE, '0, 32'h0000_1008);
    send_request(ffba_pkg::ACT_FREE, 16'hFFFF, '0);
    send_request(ffba_pkg::ACT_ALLOC, '0, 32'hFFFF_FFFF);
    set_pool(32'hFFFF_FFF0, 32'h0001_0000);
    send_request(ffba_pkg::ACT_ALLOC, 16'hFFFF, '0);
    send_request(ffba_pkg::ACT_ALLOC, 16'd65524, '0);
    send_request(ffba_pkg::ACT_ALLOC, 16'd1, '0);
    send_request(ffba_pkg::ACT_FREE, '0, 32'hFFFF_FFF8);
    send_request(ffba_pkg::ACT_ALLOC, 16'd100, '0);
    send_request(ffba_pkg::ACT_ALLOC, 16'd200, '0);
    send_request(ffba_pkg::ACT_FREE, '0, 32'hFFFF_FFF0 + 32'd65532 + HDR);
    send_request(ffba_pkg::ACT_FREE, '0, 32'hDEAD_BEEF);
    send_request(ffba_pkg::ACT_FREE, '0, 32'hFFFF_FFF0 + 32'd112 + HDR);
    write_register(ffba_pkg::CFG_POOL_SIZE, 32'hFFFF_FFFF);
    send_request(ffba_pkg::ACT_ALLOC, 16'd65524, '0);
    set_pool(32'hFFFF_FFFF, 32'h0001_FFFF);
    send_request(ffba_pkg::ACT_ALLOC, 16'd1, '0);
    send_request(ffba_pkg::ACT_FREE, '0, 32'd7);
  endtask

  task automatic test_table_full();
    set_pool(nonzero_base(), 32'h0001_0000);
    repeat (70) send_request(ffba_pkg::ACT_ALLOC, 16'($urandom_range(1, 40)), $urandom);
    repeat (20) begin
      if (live_addrs.size() != 0)
        send_request(ffba_pkg::ACT_FREE, 16'($urandom),
                     live_addrs[$urandom_range(live_addrs.size() - 1)]);
    end
    repeat (30) send_request(ffba_pkg::ACT_ALLOC, 16'($urandom_range(1, 60)), $urandom);
  endtask

  task automatic test_random_traffic();
    logic [AW-1:0] base;
    logic [SW-1:0] span;
    for (int p = 0; p < 8; p++) begin
      base = (p == 5) ? (32'hFFFF_F000 | $urandom_range(1, 32'hFFF)) : nonzero_base();
      case (p % 4)
        0: span = SW'($urandom_range(8, 512));
        1: span = SW'($urandom_range(512, 8192));
        2: span = ffba_pkg::POOL_LIMIT;
        default: span = SW'($urandom_range(65537, 131071));
      endcase
      set_pool(base, {15'($urandom), span});
      repeat (150) send_random_op();
    end
  endtask

  task automatic test_no_idle();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    set_pool(nonzero_base(), 32'd4096);
    repeat (150) send_random_op();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_pool(nonzero_base(), 32'h0001_0000);
    in_gaps_on = 1'b0;
    hold_req   = 600;
    repeat (30) send_random_op();
    in_gaps_on = 1'b1;
  endtask

  initial begin
    shadow_base = '0;
    shadow_size = '0;
    clear_table();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_not_initialised();
    test_edge_cases();
    test_table_full();
    test_random_traffic();
    test_no_idle();
    test_backpressure();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
